// File: src/bpa_pkg.sv
// Shared constants, payload types and control structs for the bitmap page allocator.
package bpa_pkg;

    // Pool geometry. Both are powers of two.
    localparam int MAX_PAGES   = 1024;
    localparam int PAGE_BYTES  = 4096;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int TOTAL_RESET = 1024;

    // Field widths fixed by the interface.
    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 11;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int TOTAL_W    = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Derived widths.
    localparam int PAGE_W    = $clog2(MAX_PAGES);
    localparam int SPAN_W    = ((PAGE_W + 1 > COUNT_W) ? PAGE_W + 1 : COUNT_W) + 1;
    localparam int PG_ADDR_W = ADDR_W - PAGE_SHIFT;
    localparam int CHK_W     = ADDR_W + 1;

    // The bitmap is held as words of WORD_BITS pages.
    localparam int WORD_BITS = 8;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int NUM_WORDS = MAX_PAGES / WORD_BITS;
    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RESERVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FREE    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_BAD     = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTALLOC = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES = 1'b1;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ADDR_W-1:0]  address;
        logic [COUNT_W-1:0] count;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   result_address;
    } rsp_t;

    typedef struct packed {
        logic                load_req;
        logic                decode;
        logic                set_req_range;
        logic                rd_en;
        logic                rd_first;
        logic                rd_scan;
        logic                scan_clr;
        logic                scan_upd;
        logic                mark_we;
        logic                emit;
        logic [STATUS_W-1:0] code;
    } cmd_t;

    typedef struct packed {
        logic bad_req;
        logic too_big;
        logic bad_range;
        logic is_alloc;
        logic is_reserve;
        logic scan_found;
        logic scan_last;
        logic check_fail;
        logic walk_last;
        logic out_busy;
    } sts_t;

endpackage

// File: src/bpa_datapath.sv
// Datapath: configuration, request registers, bitmap memory, scan and mask logic, result register.
module bpa_datapath
    import bpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  req_t                  req,
    input  logic                  rsp_ready,
    output logic                  rsp_valid,
    output rsp_t                  rsp,
    input  cmd_t                  cmd,
    output sts_t                  sts
);

    logic [ADDR_W-1:0]    pool_base_reg;
    logic [TOTAL_W-1:0]   total_pages_reg;

    logic [FUNC_W-1:0]    func_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [SPAN_W-1:0]    cnt_reg;
    logic [SPAN_W-1:0]    n_reg;
    logic                 below_reg;
    logic [PG_ADDR_W-1:0] page_reg;
    logic [SPAN_W-1:0]    lo_reg;
    logic [SPAN_W-1:0]    hi_reg;
    logic [SPAN_W-1:0]    run_reg;

    logic [WIDX_W-1:0]    rd_idx_reg;
    logic [WIDX_W-1:0]    data_idx_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 rvld_reg;
    logic [NUM_WORDS-1:0] word_vld_reg;
    logic [WORD_BITS-1:0] mem [NUM_WORDS];

    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [ADDR_W-1:0]    out_addr_reg;

    logic [SPAN_W-1:0]    tp_ext;
    logic [SPAN_W-1:0]    n_now;
    logic [ADDR_W:0]      offset;
    logic [WIDX_W-1:0]    lo_word;
    logic [WIDX_W-1:0]    last_word;
    logic [WIDX_W-1:0]    rd_addr;
    logic [WORD_BITS-1:0] word;
    logic [SPAN_W-1:0]    pg [WORD_BITS];
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] wdata;
    logic [SPAN_W-1:0]    run;
    logic                 found;
    logic [SPAN_W-1:0]    fend;
    logic                 is_free;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg   <= '0;
            total_pages_reg <= TOTAL_W'(TOTAL_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POOL_BASE:   pool_base_reg   <= cfg_wdata[ADDR_W-1:0];
                CFG_TOTAL_PAGES: total_pages_reg <= cfg_wdata[TOTAL_W-1:0];
                default:         pool_base_reg   <= pool_base_reg;
            endcase
        end
    end

    assign tp_ext  = SPAN_W'(total_pages_reg);
    assign n_now   = (tp_ext > SPAN_W'(MAX_PAGES)) ? SPAN_W'(MAX_PAGES) : tp_ext;
    assign offset  = {1'b0, addr_reg} - {1'b0, pool_base_reg};
    assign is_free = (func_reg == FUNC_FREE);

    // Page numbers of the bits in the word currently presented by the memory.
    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            pg[j]   = (SPAN_W'(data_idx_reg) << BIT_W) | SPAN_W'(j);
            mask[j] = (pg[j] >= lo_reg) && (pg[j] < hi_reg);
        end
    end

    // A word that was never written reads as all free through its per-word valid bit.
    assign word      = rvld_reg ? rdata_reg : '0;
    assign wdata     = is_free ? (word & ~mask) : (word | mask);
    assign lo_word   = WIDX_W'(lo_reg >> BIT_W);
    assign last_word = WIDX_W'((hi_reg - SPAN_W'(1)) >> BIT_W);
    assign rd_addr   = cmd.rd_first ? (cmd.rd_scan ? '0 : lo_word) : rd_idx_reg + WIDX_W'(1);

    // First-fit run search over the pages of one word.
    always_comb
    begin
        run   = run_reg;
        found = 1'b0;
        fend  = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (!found && (pg[j] < n_reg))
            begin
                run = word[j] ? '0 : run + SPAN_W'(1);
                if (run == cnt_reg)
                begin
                    found = 1'b1;
                    fend  = pg[j];
                end
            end
        end
    end

    // Request and walk registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            func_reg <= req.func;
            addr_reg <= req.address;
            cnt_reg  <= SPAN_W'(req.count);
            n_reg    <= n_now;
        end
        if (cmd.decode)
        begin
            below_reg <= offset[ADDR_W];
            page_reg  <= offset[ADDR_W-1:PAGE_SHIFT];
        end
        if (cmd.set_req_range)
        begin
            lo_reg <= SPAN_W'(page_reg);
            hi_reg <= SPAN_W'(page_reg) + cnt_reg;
        end
        if (cmd.scan_clr)
        begin
            run_reg <= '0;
        end
        if (cmd.scan_upd)
        begin
            run_reg <= run;
            if (found)
            begin
                lo_reg <= fend + SPAN_W'(1) - cnt_reg;
                hi_reg <= fend + SPAN_W'(1);
            end
        end
        if (cmd.rd_en)
        begin
            rd_idx_reg   <= rd_addr;
            data_idx_reg <= rd_addr;
        end
    end

    // Bitmap memory.
    always_ff @(posedge clk)
    begin
        if (cmd.mark_we)
        begin
            mem[data_idx_reg] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_vld_reg <= '0;
            rvld_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.mark_we)
            begin
                word_vld_reg[data_idx_reg] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rvld_reg <= word_vld_reg[rd_addr];
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg <= cmd.code;
            out_addr_reg   <= (cmd.code == ST_OK && func_reg == FUNC_ALLOC)
                              ? pool_base_reg + (ADDR_W'(lo_reg) << PAGE_SHIFT) : '0;
        end
    end

    assign rsp_valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.result_address  = out_addr_reg;

    assign sts.bad_req    = (cnt_reg == '0) || (func_reg == FUNC_BAD);
    assign sts.too_big    = cnt_reg > n_reg;
    assign sts.bad_range  = below_reg
                            || (CHK_W'(page_reg) >= CHK_W'(n_reg))
                            || (CHK_W'(page_reg) + CHK_W'(cnt_reg) > CHK_W'(n_reg));
    assign sts.is_alloc   = (func_reg == FUNC_ALLOC);
    assign sts.is_reserve = (func_reg == FUNC_RESERVE);
    assign sts.scan_found = found;
    assign sts.scan_last  = (SPAN_W'(data_idx_reg) << BIT_W) + SPAN_W'(WORD_BITS) >= n_reg;
    assign sts.check_fail = (func_reg == FUNC_RESERVE) ? |(word & mask) : |(~word & mask);
    assign sts.walk_last  = (data_idx_reg == last_word);
    assign sts.out_busy   = out_valid_reg && !rsp_ready;

endmodule

// File: src/bpa_ctrl.sv
// Controller state machine that sequences decode, bitmap scan, range check and marking.
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RANGE,
        S_CHECK_RD,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN,
        S_MARK_RD,
        S_MARK,
        S_DONE
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [STATUS_W-1:0] code_reg;
    logic [STATUS_W-1:0] code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end

            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (sts.bad_req)
                begin
                    code_next  = ST_RANGE;
                    state_next = S_DONE;
                end
                else if (sts.is_alloc)
                begin
                    if (sts.too_big)
                    begin
                        code_next  = ST_NOSPACE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    state_next = S_RANGE;
                end
            end

            S_RANGE:
            begin
                if (sts.bad_range)
                begin
                    code_next  = ST_RANGE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.set_req_range = 1'b1;
                    state_next        = S_CHECK_RD;
                end
            end

            S_CHECK_RD:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = 1'b1;
                state_next   = S_CHECK;
            end

            S_CHECK:
            begin
                if (sts.check_fail)
                begin
                    code_next  = sts.is_reserve ? ST_NOSPACE : ST_NOTALLOC;
                    state_next = S_DONE;
                end
                else if (sts.walk_last)
                begin
                    state_next = S_MARK_RD;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end

            S_SCAN_RD:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = 1'b1;
                cmd.rd_scan  = 1'b1;
                cmd.scan_clr = 1'b1;
                state_next   = S_SCAN;
            end

            S_SCAN:
            begin
                cmd.scan_upd = 1'b1;
                if (sts.scan_found)
                begin
                    state_next = S_MARK_RD;
                end
                else if (sts.scan_last)
                begin
                    code_next  = ST_NOSPACE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end

            S_MARK_RD:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = 1'b1;
                state_next   = S_MARK;
            end

            S_MARK:
            begin
                cmd.mark_we = 1'b1;
                if (sts.walk_last)
                begin
                    code_next  = ST_OK;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end

            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/bitmap_page_allocator_top.sv
// Top level of the bitmap first-fit page allocator.
//
//   Channel   Direction  Handshake              Payload
//   req       in         req_valid / req_ready  req_t: func, address, count
//   rsp       out        rsp_valid / rsp_ready  rsp_t: status, result_address
//   cfg       in         cfg_we                 cfg_index, cfg_wdata
//
// One request is handled at a time; the bitmap is walked one 8-page memory word per cycle
// through a single read port with registered read data.
// Allocate scans words up to the end of the first fitting run, then marks the words that run
// touches; an allocate that finds no room stops once the scan reaches the end of the pool.
// Reserve and free check every word of the range and then mark it; one that meets a page
// in the wrong state stops at the word where it meets it.
// A bad func or count, or an allocate larger than the pool, finishes after decode, and a bad
// range finishes after the range check.
// Reset clears the bitmap at once through per-word valid bits; no clearing pass is needed.
// A finished result waits in the output register while the next request is taken in.
module bitmap_page_allocator_top
    import bpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp
);

    cmd_t cmd;
    sts_t sts;

    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bpa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// File: verif/bitmap_page_allocator_top_tb.sv
// Self-checking testbench for the bitmap page allocator: directed table, then random phases.
`timescale 1ns / 1ps

module bitmap_page_allocator_top_tb
    import bpa_pkg::*;
();

    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 800;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 50;

    typedef struct {
        bit                 is_cfg;
        req_t               item;
        bit                 fixed;
        rsp_t               fixed_rsp;
        logic [ADDR_W-1:0]  base;
        logic [TOTAL_W-1:0] total;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_POOL_BASE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req       = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp;

    // Shadow of the allocator state, updated as each request transaction is accepted.
    bit                 page_busy [MAX_PAGES];
    logic [ADDR_W-1:0]  pool_base_now   = '0;
    logic [TOTAL_W-1:0] total_pages_now = TOTAL_W'(TOTAL_RESET);

    rsp_t      awaited_results[$];
    plan_row_t plan_q[$];
    int        error_count      = 0;
    int        burst_left       = 0;
    int        settings_seen    = 1;
    int        func_seen[4]     = '{default: 0};
    int        status_seen[4]   = '{default: 0};
    bit        hold_off_pending = 1'b0;

    bitmap_page_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int pages_in_force();
        return (int'(total_pages_now) > MAX_PAGES) ? MAX_PAGES : int'(total_pages_now);
    endfunction

    // Works out the response to one request and applies its effect to the shadow bitmap.
    function automatic rsp_t apply_page_request(input req_t r);
        rsp_t              o;
        int                n;
        int                run;
        int                first;
        int                page;
        bit                found;
        bit                want;
        logic [ADDR_W-1:0] offset;
        o.status         = ST_OK;
        o.result_address = '0;
        n     = pages_in_force();
        run   = 0;
        first = 0;
        found = 1'b0;
        if (r.count == 0 || r.func == FUNC_BAD)
        begin
            o.status = ST_RANGE;
        end
        else if (r.func == FUNC_ALLOC)
        begin
            for (int i = 0; i < n; i++)
            begin
                if (!found)
                begin
                    run = page_busy[i] ? 0 : run + 1;
                    if (run == int'(r.count))
                    begin
                        found = 1'b1;
                        first = i + 1 - int'(r.count);
                    end
                end
            end
            if (found)
            begin
                for (int i = first; i < first + int'(r.count); i++)
                    page_busy[i] = 1'b1;
                o.result_address = pool_base_now + (ADDR_W'(first) << PAGE_SHIFT);
            end
            else
            begin
                o.status = ST_NOSPACE;
            end
        end
        else if (r.address < pool_base_now)
        begin
            o.status = ST_RANGE;
        end
        else
        begin
            offset = r.address - pool_base_now;
            page   = int'(offset >> PAGE_SHIFT);
            if (page >= n || page + int'(r.count) > n)
            begin
                o.status = ST_RANGE;
            end
            else
            begin
                // Reserve needs every page free, free needs every page in use.
                want = (r.func == FUNC_FREE);
                for (int i = page; i < page + int'(r.count); i++)
                    if (o.status == ST_OK && page_busy[i] != want)
                        o.status = (r.func == FUNC_RESERVE) ? ST_NOSPACE : ST_NOTALLOC;
                if (o.status == ST_OK)
                    for (int i = page; i < page + int'(r.count); i++)
                        page_busy[i] = !want;
            end
        end
        return o;
    endfunction

    function automatic req_t next_random_request();
        req_t r;
        int   n;
        int   pick;
        int   start;
        int   first;
        int   len;
        int   idx;
        bit   found;
        bit   want;
        n    = pages_in_force();
        pick = $urandom_range(0, 99);
        r.address = $urandom;
        if (pick < 12)
        begin
            r.func  = FUNC_W'($urandom_range(0, 3));
            r.count = COUNT_W'($urandom_range(0, 2047));
        end
        else if (pick < 47)
        begin
            r.func = FUNC_ALLOC;
            if ($urandom_range(0, 7) == 0)
                r.count = COUNT_W'($urandom_range(1, n));
            else
                r.count = COUNT_W'($urandom_range(1, (n < 6) ? n : 6));
        end
        else
        begin
            r.func = (pick < 82) ? FUNC_FREE : FUNC_RESERVE;
            want   = (r.func == FUNC_FREE);
            start  = $urandom_range(0, n - 1);
            found  = 1'b0;
            first  = start;
            len    = 0;
            // Look for the next page in the wanted state, wrapping round the pool.
            for (int k = 0; k < n; k++)
            begin
                idx = (start + k) % n;
                if (!found && page_busy[idx] == want)
                begin
                    found = 1'b1;
                    first = idx;
                end
            end
            if (found)
                for (int j = first; j < n; j++)
                    if (len == j - first && page_busy[j] == want)
                        len++;
            if (!found)
                r.count = COUNT_W'($urandom_range(1, 4));
            else if ($urandom_range(0, 9) == 0)
                r.count = COUNT_W'(len + 1);
            else
                r.count = COUNT_W'($urandom_range(1, len));
            r.address = pool_base_now + (ADDR_W'(first) << PAGE_SHIFT)
                        + ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
        end
        return r;
    endfunction

    function automatic void plan_request(input logic [FUNC_W-1:0] func,
                                         input logic [ADDR_W-1:0] address,
                                         input int count, input bit fixed,
                                         input logic [STATUS_W-1:0] status,
                                         input logic [ADDR_W-1:0] result_address);
        plan_row_t row;
        row.is_cfg                   = 1'b0;
        row.item.func                = func;
        row.item.address             = address;
        row.item.count               = COUNT_W'(count);
        row.fixed                    = fixed;
        row.fixed_rsp.status         = status;
        row.fixed_rsp.result_address = result_address;
        row.base                     = '0;
        row.total                    = '0;
        plan_q.push_back(row);
    endfunction

    function automatic void plan_config(input logic [ADDR_W-1:0] base,
                                        input logic [TOTAL_W-1:0] total);
        plan_row_t row;
        row       = '{default: '0};
        row.is_cfg = 1'b1;
        row.base   = base;
        row.total  = total;
        plan_q.push_back(row);
    endfunction

    task automatic drive_request(input req_t item, input bit fixed, input rsp_t fixed_rsp);
        rsp_t predicted;
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        predicted = apply_page_request(item);
        if (fixed)
            predicted = fixed_rsp;
        awaited_results.push_back(predicted);
        func_seen[item.func]++;
        status_seen[predicted.status]++;
    endtask

    // Bursts of back-to-back transactions separated by random gaps.
    task automatic sender_gap();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [ADDR_W-1:0] base, input logic [TOTAL_W-1:0] total);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_POOL_BASE;
        cfg_wdata <= base;
        @(posedge clk);
        cfg_index <= CFG_TOTAL_PAGES;
        cfg_wdata <= CFG_DATA_W'(total);
        @(posedge clk);
        cfg_we <= 1'b0;
        pool_base_now   = base;
        total_pages_now = total;
        settings_seen++;
    endtask

    task automatic check_response(input rsp_t got);
        rsp_t want;
        if (awaited_results.size() == 0)
        begin
            $display("%0t: unexpected response: status %0d address %h",
                     $time, got.status, got.result_address);
            error_count++;
        end
        else
        begin
            want = awaited_results.pop_front();
            if (got.status !== want.status)
            begin
                $display("%0t: status mismatch: expected %0d, got %0d",
                         $time, want.status, got.status);
                error_count++;
            end
            if (got.result_address !== want.result_address)
            begin
                $display("%0t: result_address mismatch: expected %h, got %h",
                         $time, want.result_address, got.result_address);
                error_count++;
            end
        end
    endtask

    // Response side: checks each accepted transaction and stalls on a pattern of its own.
    initial
    begin : response_side
        int mode;
        int mode_left;
        int hold_left;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                check_response(rsp);
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                hold_left        = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ready <= ((mode_left % 7) >= 2);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d responses outstanding.",
                 cycles, awaited_results.size());
        $display("bitmap_page_allocator_top regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        logic [ADDR_W-1:0]  base;
        logic [TOTAL_W-1:0] total;
        // Reset state: base 0, full pool of 1024 pages.
        plan_request(FUNC_ALLOC,   32'hFFFF_FFFF, 1,    1, ST_OK,       32'h0);
        plan_request(FUNC_ALLOC,   32'h0,         0,    1, ST_RANGE,    32'h0);
        plan_request(FUNC_BAD,     32'h0,         5,    1, ST_RANGE,    32'h0);
        plan_request(FUNC_ALLOC,   32'h0,         2047, 1, ST_NOSPACE,  32'h0);
        plan_request(FUNC_ALLOC,   32'h0,         1024, 1, ST_NOSPACE,  32'h0);
        plan_request(FUNC_FREE,    32'h0,         1,    1, ST_OK,       32'h0);
        plan_request(FUNC_ALLOC,   32'h0,         1024, 1, ST_OK,       32'h0);
        plan_request(FUNC_RESERVE, 32'h0000_0FFF, 1,    1, ST_NOSPACE,  32'h0);
        plan_request(FUNC_FREE,    32'h0,         1024, 0, ST_OK,       32'h0);
        plan_request(FUNC_FREE,    32'h0000_1000, 1,    1, ST_NOTALLOC, 32'h0);
        plan_request(FUNC_RESERVE, 32'hFFFF_F000, 1,    1, ST_RANGE,    32'h0);
        plan_request(FUNC_RESERVE, 32'h003F_FFFF, 1,    0, ST_OK,       32'h0);
        plan_request(FUNC_RESERVE, 32'h003F_F000, 2,    1, ST_RANGE,    32'h0);
        plan_request(FUNC_FREE,    32'h003F_FABC, 1,    0, ST_OK,       32'h0);
        // A pool at the top of the address space wraps round to zero; the page
        // count above the bitmap depth is clipped.
        plan_config(32'hFFFF_F000, 11'd2047);
        plan_request(FUNC_ALLOC,   32'h0,         2,    1, ST_OK,       32'hFFFF_F000);
        plan_request(FUNC_ALLOC,   32'h0,         1,    1, ST_OK,       32'h0000_1000);
        plan_request(FUNC_RESERVE, 32'h0,         1,    1, ST_RANGE,    32'h0);
        plan_request(FUNC_FREE,    32'hFFFF_F000, 3,    0, ST_OK,       32'h0);
        plan_config(32'h8000_0000, 11'd1);
        plan_request(FUNC_ALLOC,   32'h0,         2,    1, ST_NOSPACE,  32'h0);
        plan_request(FUNC_ALLOC,   32'h0,         1,    1, ST_OK,       32'h8000_0000);
        plan_request(FUNC_RESERVE, 32'h8000_0000, 1,    0, ST_OK,       32'h0);
        plan_request(FUNC_FREE,    32'h8000_0000, 1,    0, ST_OK,       32'h0);
        plan_request(FUNC_FREE,    32'h8000_1000, 1,    1, ST_RANGE,    32'h0);
        // With no pages at all every allocation fails.
        plan_config(32'h5555_A000, 11'd0);
        plan_request(FUNC_ALLOC,   32'h0,         1,    1, ST_NOSPACE,  32'h0);
        plan_request(FUNC_RESERVE, 32'h5555_A000, 1,    1, ST_RANGE,    32'h0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_q[i])
        begin
            if (plan_q[i].is_cfg)
            begin
                wait_idle();
                set_config(plan_q[i].base, plan_q[i].total);
            end
            else
            begin
                sender_gap();
                drive_request(plan_q[i].item, plan_q[i].fixed, plan_q[i].fixed_rsp);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       total = 11'd1024;
                1:       total = TOTAL_W'($urandom_range(1, 16));
                2:       total = 11'd8;
                3:       total = 11'd2047;
                4:       total = TOTAL_W'($urandom_range(1, 64));
                5:       total = 11'd1;
                6:       total = TOTAL_W'($urandom_range(17, 300));
                default: total = TOTAL_W'($urandom_range(1, 32));
            endcase
            if (ph == 0)
                base = '0;
            else if (ph == 3 || ph == 5)
                base = $urandom;
            else
                base = $urandom & 32'hFFC0_0000;
            // Every phase starts from an idle block, with all responses in.
            wait_idle();
            set_config(base, total);
            // Hold the response side off while requests keep coming, so the block backs up.
            if (ph == 2)
                hold_off_pending = 1'b1;
            repeat (PHASE_ITEMS)
            begin
                sender_gap();
                drive_request(next_random_request(), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        $display("Covered %0d allocate, %0d reserve, %0d free and %0d invalid requests",
                 func_seen[FUNC_ALLOC], func_seen[FUNC_RESERVE], func_seen[FUNC_FREE],
                 func_seen[FUNC_BAD]);
        $display("over %0d register settings; statuses ok %0d, no space %0d, %s %0d, %s %0d.",
                 settings_seen, status_seen[ST_OK], status_seen[ST_NOSPACE],
                 "not allocated", status_seen[ST_NOTALLOC],
                 "bad range", status_seen[ST_RANGE]);
        if (error_count == 0)
            $display("bitmap_page_allocator_top regression: pass");
        else
            $display("bitmap_page_allocator_top regression: fail");
        $finish;
    end

endmodule
